/* hw/rtl/btpc_pkg.sv */
// btpc_pkg: shared types and constants for the pressure compensation block
// no dependencies
package btpc_pkg;

    localparam logic [1:0] REG_AC_S = 2'd0;
    localparam logic [1:0] REG_AC_U = 2'd1;
    localparam logic [1:0] REG_B_M  = 2'd2;
    localparam logic [1:0] REG_OSS  = 2'd3;

    // datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_T_LOAD,   // a = (ut - ac6) * ac5
        OP_T_X1,     // x1 = a / 32768, check den
        OP_T_DIVS,   // start mc*2048 / den
        OP_T_FIN,    // b5, value
        OP_P_LOAD,   // up, b6
        OP_P_SQ,     // b6*b6 >>> 12
        OP_P_M1,     // b2*sq >>> 11
        OP_P_M2,     // ac2*b6 >>> 11
        OP_P_B3,     // b3
        OP_P_M3,     // ac3*b6 >>> 13
        OP_P_M4,     // b1*sq >>> 16
        OP_P_X3,     // x3
        OP_P_B4,     // b4
        OP_P_B7,     // b7
        OP_P_DIVS,   // start p division
        OP_P_PFIX,   // p fixups
        OP_P_Q,      // (p>>>8)^2
        OP_P_Q2,     // *3038 >>> 16
        OP_P_Q3,     // -7357*p >>> 16
        OP_P_FIN     // value
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic zero_den;
    } t_stat;

    localparam int DIV_W = 32;

endpackage

/* hw/rtl/baro_temp_pressure_compensate.sv */
// baro_temp_pressure_compensate: top level, registers, output word register
// depends on btpc_pkg, btpc_ctrl, btpc_dp
//
// usage
//   s_axis: one word per sensor reading; tuser = cmd (0 temp, 1 pressure),
//   tdata = msb, lsb, xlsb from bit 0 up.
//   m_axis: one word per reading; tuser = kind, div_error from bit 0 up,
//   tdata = signed value (0.1 degrees or pascals).
//   cfg: i_cfg_valid/o_cfg_ready with register index and data, write only
//   when idle; index 0 AC1..AC3, 1 AC4..AC6, 2 B1,B2,MC,MD, 3 oversampling.
// timing
//   a temperature or a pressure word shows on m_axis once the sequencer has
//   run its steps on the one shared multiplier and the single 32-bit radix-2
//   divider; a zero divisor sends the word out without the divider.
//   one word in flight at a time; the next input is taken once the result
//   has moved into the output register, so input overlaps an output stall.
// reset
//   synchronous active-low; clears registers, stored b5 and the output valid.
//   a stalled receiver holds the result in the output register; the block
//   finishes a following word and waits until the register frees.
module baro_temp_pressure_compensate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // msb, lsb, xlsb
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [1:0]  m_axis_tuser,   // kind, div_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import btpc_pkg::*;

    logic [47:0] r_ac_s, r_ac_u;
    logic [63:0] r_b_m;
    logic [1:0]  r_oss;
    logic        r_mvalid;
    logic [31:0] r_mdata;
    logic [1:0]  r_muser;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle, w_done, w_start, w_kind, w_err, w_out_free;
    logic [31:0] w_value;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;
    assign w_out_free    = !r_mvalid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac_s <= '0;
            r_ac_u <= '0;
            r_b_m  <= '0;
            r_oss  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AC_S: r_ac_s <= i_cfg_data[47:0];
                REG_AC_U: r_ac_u <= i_cfg_data[47:0];
                REG_B_M:  r_b_m  <= i_cfg_data;
                REG_OSS:  r_oss  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    btpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (s_axis_tuser),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle),
        .o_done     (w_done)
    );

    btpc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_start),
        .i_kind  (s_axis_tuser),
        .i_msb   (s_axis_tdata[7:0]),
        .i_lsb   (s_axis_tdata[15:8]),
        .i_xlsb  (s_axis_tdata[23:16]),
        .i_ac_s  (r_ac_s),
        .i_ac_u  (r_ac_u),
        .i_b_m   (r_b_m),
        .i_oss   (r_oss),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_kind  (w_kind),
        .o_value (w_value),
        .o_err   (w_err)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_done) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_mdata <= w_err ? 32'd0 : w_value;
            r_muser <= {w_err, w_kind};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && !m_axis_tready) |-> !w_done) else $error("output overwritten");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready) else $error("accepted while busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tdata == 32'd0)
        else $error("error word carries value");
endmodule

/* hw/rtl/btpc_ctrl.sv */
// btpc_ctrl: sequencer issuing one datapath operation per step
// depends on btpc_pkg
module btpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_kind,
    input  btpc_pkg::t_stat i_stat,
    input  logic            i_out_free,
    output btpc_pkg::t_cmd  o_cmd,
    output logic            o_idle,
    output logic            o_done
);
    import btpc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        o_cmd.op  = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_op    = i_kind ? OP_P_LOAD : OP_T_LOAD;
                end
            end
            S_RUN: begin
                o_cmd.op = r_op;
                case (r_op)
                    OP_T_X1: begin
                        if (i_stat.zero_den) n_state = S_OUT;
                        else n_op = OP_T_DIVS;
                    end
                    OP_T_DIVS: begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_WAIT;
                        n_op = OP_T_FIN;
                    end
                    OP_T_FIN, OP_P_FIN: n_state = S_OUT;
                    OP_P_B7: begin
                        if (i_stat.zero_den) n_state = S_OUT;
                        else n_op = OP_P_DIVS;
                    end
                    OP_P_DIVS: begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_WAIT;
                        n_op = OP_P_PFIX;
                    end
                    default: n_op = t_op'(r_op + 5'd1);
                endcase
            end
            S_WAIT: begin
                if (!i_stat.div_busy) n_state = S_RUN;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    a_done_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_OUT) else $error("done outside output state");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle && i_start) |=> r_state == S_RUN) else $error("start lost");
    a_div_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_WAIT) else $error("divider not awaited");
endmodule

/* hw/rtl/btpc_div.sv */
// btpc_div: radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on btpc_pkg
module btpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [btpc_pkg::DIV_W-1:0]    i_num,
    input  logic [btpc_pkg::DIV_W-1:0]    i_den,
    output logic                          o_busy,
    output logic [btpc_pkg::DIV_W-1:0]    o_quo
);
    import btpc_pkg::*;

    logic [DIV_W-1:0] r_quo, r_den;
    logic [DIV_W:0]   r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [DIV_W:0]   w_shift, w_diff;

    assign w_shift = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

/* hw/rtl/btpc_dp.sv */
// btpc_dp: datapath registers, one multiplier and the shared divider
// depends on btpc_pkg, btpc_div
module btpc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_kind,
    input  logic [7:0]      i_msb,
    input  logic [7:0]      i_lsb,
    input  logic [7:0]      i_xlsb,
    input  logic [47:0]     i_ac_s,
    input  logic [47:0]     i_ac_u,
    input  logic [63:0]     i_b_m,
    input  logic [1:0]      i_oss,
    input  btpc_pkg::t_cmd  i_cmd,
    output btpc_pkg::t_stat o_stat,
    output logic            o_kind,
    output logic [31:0]     o_value,
    output logic            o_err
);
    import btpc_pkg::*;

    logic [7:0]  r_msb, r_lsb, r_xlsb;
    logic        r_kind, r_err;
    logic [31:0] r_b5, r_a, r_x1, r_x2, r_sq, r_b6, r_b3, r_b4, r_b7, r_p, r_up, r_val;
    logic        r_neg;
    logic [31:0] w_ma, w_mb, w_prod, w_num, w_den, w_quo;
    logic        w_busy;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

    assign ac1 = sx(i_ac_s[47:32]);
    assign ac2 = sx(i_ac_s[31:16]);
    assign ac3 = sx(i_ac_s[15:0]);
    assign ac4 = {16'd0, i_ac_u[47:32]};
    assign ac5 = {16'd0, i_ac_u[31:16]};
    assign ac6 = {16'd0, i_ac_u[15:0]};
    assign b1  = sx(i_b_m[63:48]);
    assign b2  = sx(i_b_m[47:32]);
    assign mc  = sx(i_b_m[31:16]);
    assign md  = sx(i_b_m[15:0]);

    // single shared 32x32 multiplier, low word kept
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_T_LOAD: begin w_ma = {16'd0, r_msb, r_lsb} - ac6; w_mb = ac5; end
            OP_P_SQ:   begin w_ma = r_b6; w_mb = r_b6; end
            OP_P_M1:   begin w_ma = b2;   w_mb = r_sq; end
            OP_P_M2:   begin w_ma = ac2;  w_mb = r_b6; end
            OP_P_M3:   begin w_ma = ac3;  w_mb = r_b6; end
            OP_P_M4:   begin w_ma = b1;   w_mb = r_sq; end
            OP_P_B4:   begin w_ma = ac4;  w_mb = r_x1 + 32'd32768; end
            OP_P_B7:   begin w_ma = r_up - r_b3; w_mb = 32'd50000 >> i_oss; end
            OP_P_Q:    begin w_ma = asr(r_p, 5'd8); w_mb = asr(r_p, 5'd8); end
            OP_P_Q2:   begin w_ma = r_x1; w_mb = 32'd3038; end
            OP_P_Q3:   begin w_ma = 32'd0 - 32'd7357; w_mb = r_p; end
            default: ;
        endcase
    end
    assign w_prod = 32'(w_ma * w_mb);

    // signed or unsigned operand selection for the divider
    always_comb begin
        w_num = '0;
        w_den = '0;
        if (i_cmd.op == OP_T_DIVS) begin
            // magnitude of mc * 2048
            w_num = mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
            w_den = r_x2[31] ? 32'd0 - r_x2 : r_x2;
        end else begin
            w_num = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
            w_den = r_b4;
        end
    end

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= '0;
        end else if (i_cmd.op == OP_T_FIN) begin
            r_b5 <= r_x1 + (r_neg ? 32'd0 - w_quo : w_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_kind;
            r_msb  <= i_msb;
            r_lsb  <= i_lsb;
            r_xlsb <= i_xlsb;
            r_err  <= 1'b0;
            r_val  <= '0;
        end
        case (i_cmd.op)
            OP_T_LOAD: r_a <= w_prod;
            OP_T_X1: begin
                // signed divide by 32768, truncating toward zero
                r_x1 <= asr(r_a + (r_a[31] ? 32'd32767 : 32'd0), 5'd15);
                r_x2 <= asr(r_a + (r_a[31] ? 32'd32767 : 32'd0), 5'd15) + md;
                if (asr(r_a + (r_a[31] ? 32'd32767 : 32'd0), 5'd15) + md == 32'd0)
                    r_err <= 1'b1;
            end
            OP_T_DIVS: begin
                r_neg <= (mc[31] ^ r_x2[31]);
            end
            OP_T_FIN: r_val <= asr(r_x1 + (r_neg ? 32'd0 - w_quo : w_quo) + 32'd8, 5'd4);
            OP_P_LOAD: begin
                r_up <= {8'd0, r_msb, r_lsb, r_xlsb} >> (4'd8 - {2'b00, i_oss});
                r_b6 <= r_b5 - 32'd4000;
            end
            OP_P_SQ: r_sq <= asr(w_prod, 5'd12);
            OP_P_M1: r_x1 <= asr(w_prod, 5'd11);
            OP_P_M2: r_x2 <= asr(w_prod, 5'd11);
            OP_P_B3: r_b3 <= asr((((ac1 << 2) + r_x1 + r_x2) << i_oss) + 32'd2, 5'd2);
            OP_P_M3: r_x1 <= asr(w_prod, 5'd13);
            OP_P_M4: r_x2 <= asr(w_prod, 5'd16);
            OP_P_X3: r_x1 <= asr(r_x1 + r_x2 + 32'd2, 5'd2);
            OP_P_B4: r_b4 <= {15'd0, w_prod[31:15]};
            OP_P_B7: begin
                r_b7 <= w_prod;
                if (r_b4 == 32'd0) r_err <= 1'b1;
            end
            OP_P_PFIX: r_p <= r_b7[31] ? {w_quo[30:0], 1'b0} : w_quo;
            OP_P_Q:  r_x1 <= w_prod;
            OP_P_Q2: r_x1 <= asr(w_prod, 5'd16);
            OP_P_Q3: r_x2 <= asr(w_prod, 5'd16);
            OP_P_FIN: r_val <= r_p + asr(r_x1 + r_x2 + 32'd3791, 5'd4);
            default: ;
        endcase
    end

    assign o_stat.div_busy = w_busy;
    assign o_stat.zero_den = (i_cmd.op == OP_T_X1)
        ? (asr(r_a + (r_a[31] ? 32'd32767 : 32'd0), 5'd15) + md == 32'd0)
        : (r_b4 == 32'd0);
    assign o_kind  = r_kind;
    assign o_value = r_val;
    assign o_err   = r_err;
endmodule

/* test/baro_temp_pressure_compensate_tb.sv */
// self-checking testbench for baro_temp_pressure_compensate: random readings with
// an in-bench compensation predictor and a word-by-word scoreboard
// depends on btpc_pkg and the block's rtl
`timescale 1ns / 1ps

module baro_temp_pressure_compensate_tb;
    import btpc_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic [7:0] msb;
        logic [7:0] lsb;
        logic [7:0] xlsb;
    } t_reading;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        div_error;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // msb, lsb, xlsb
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // value
    logic [1:0]  m_axis_tuser;   // kind, div_error
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    baro_temp_pressure_compensate dut (.*);

    // predictor copy of the registers and stored b5
    logic [47:0] mdl_ac_s, mdl_ac_u;
    logic [63:0] mdl_bm;
    logic [1:0]  mdl_oss;
    logic [31:0] mdl_b5;

    t_reading pending_readings[$];
    t_comp    expected_comps[$];
    int       mismatches;
    int       sender_idle_pct, receiver_stall_pct;
    longint   cycle_count;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    // truncating signed divide on 32-bit patterns, -2^31 / -1 wraps
    function automatic logic [31:0] sdiv32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input t_reading r);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b6, sq, b3, b4, b7, p, oss;
        t_comp c;
        ac1 = sx16(mdl_ac_s[47:32]); ac2 = sx16(mdl_ac_s[31:16]); ac3 = sx16(mdl_ac_s[15:0]);
        ac4 = {16'd0, mdl_ac_u[47:32]}; ac5 = {16'd0, mdl_ac_u[31:16]};
        ac6 = {16'd0, mdl_ac_u[15:0]};
        b1 = sx16(mdl_bm[63:48]); b2 = sx16(mdl_bm[47:32]);
        mc = sx16(mdl_bm[31:16]); md = sx16(mdl_bm[15:0]);
        c.kind = r.cmd;
        c.value = '0;
        c.div_error = 1'b0;
        oss = {30'd0, mdl_oss};
        if (!r.cmd) begin
            ut = {16'd0, r.msb, r.lsb};
            x1 = sdiv32((ut - ac6) * ac5, 32'd32768);
            den = x1 + md;
            if (den == 0) begin
                c.div_error = 1'b1;
            end else begin
                x2 = sdiv32(mc * 32'd2048, den);
                mdl_b5 = x1 + x2;
                c.value = sra(mdl_b5 + 32'd8, 4);
            end
        end else begin
            up = {8'd0, r.msb, r.lsb, r.xlsb} >> (8 - oss);
            b6 = mdl_b5 - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss);
            if (b4 == 0) begin
                c.div_error = 1'b1;
            end else begin
                if (!b7[31]) p = (b7 * 32'd2) / b4;
                else p = (b7 / b4) * 32'd2;
                x1 = sra(p, 8) * sra(p, 8);
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra(-32'd7357 * p, 16);
                c.value = p + sra(x1 + x2 + 32'd3791, 4);
            end
        end
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: next reading from the queue, random idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_readings.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                t_reading r;
                r = pending_readings.pop_front();
                expected_comps.push_back(compensate(r));
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= r.cmd;
                s_axis_tdata  <= {r.xlsb, r.lsb, r.msb};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls and output word check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_comps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word value=%h user=%b", m_axis_tdata, m_axis_tuser);
                end else begin
                    t_comp e;
                    e = expected_comps.pop_front();
                    if (m_axis_tdata !== e.value || m_axis_tuser[0] !== e.kind
                            || m_axis_tuser[1] !== e.div_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp kind=%b val=%h err=%b got kind=%b val=%h err=%b",
                                e.kind, e.value, e.div_error,
                                m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
                    end
                end
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("FAIL baro_temp_pressure_compensate");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_AC_S: mdl_ac_s = data[47:0];
            REG_AC_U: mdl_ac_u = data[47:0];
            REG_B_M:  mdl_bm = data;
            default:  mdl_oss = data[1:0];
        endcase
    endtask

    // typical calibration (style 0), fully random (1) or extreme values (2, 3)
    task automatic set_coefs(input int style);
        logic [63:0] a, u, m;
        if (style == 0) begin
            a = {16'd408, -16'sd72, -16'sd14383};
            u = {16'd32741, 16'd32757, 16'd23153};
            m = {16'd6190, 16'd4, -16'sd8711, 16'd2868};
        end else if (style == 1) begin
            a = {$urandom, $urandom};
            u = {$urandom, $urandom};
            m = {$urandom, $urandom};
        end else if (style == 2) begin
            a = {16'h7fff, 16'h8000, 16'h7fff};
            u = {16'hffff, 16'hffff, 16'hffff};
            m = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        end else begin
            a = {16'h8000, 16'h7fff, 16'h8000};
            u = {16'd0, 16'd1, 16'd0};
            m = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        end
        write_reg(REG_AC_S, a);
        write_reg(REG_AC_U, u);
        write_reg(REG_B_M, m);
    endtask

    task automatic push_reading(input logic cmd, input logic [7:0] m, input logic [7:0] l,
                                input logic [7:0] x);
        t_reading r;
        r.cmd = cmd; r.msb = m; r.lsb = l; r.xlsb = x;
        pending_readings.push_back(r);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        while ((pending_readings.size() > 0 || expected_comps.size() > 0 || s_axis_tvalid)
               && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mdl_ac_s = '0; mdl_ac_u = '0; mdl_bm = '0; mdl_oss = '0; mdl_b5 = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pressure before any temperature, all-zero coefficients (zero divisors)
        push_reading(1'b1, 8'h00, 8'h00, 8'h00);
        push_reading(1'b0, 8'hff, 8'hff, 8'hff);
        push_reading(1'b1, 8'hff, 8'hff, 8'hff);
        drain();
        set_coefs(0);
        write_reg(REG_OSS, 64'd0);
        push_reading(1'b1, 8'h5d, 8'h23, 8'h00);  // uses b5 still zero
        push_reading(1'b0, 8'h6c, 8'hfa, 8'haa);  // extra byte ignored
        push_reading(1'b1, 8'h5d, 8'h23, 8'h00);
        push_reading(1'b0, 8'h00, 8'h00, 8'h00);
        push_reading(1'b1, 8'hff, 8'hff, 8'hff);
        push_reading(1'b0, 8'hff, 8'hff, 8'h00);
        push_reading(1'b1, 8'h00, 8'h00, 8'h00);
        drain();
        write_reg(REG_OSS, 64'd3);
        for (int k = 0; k < 4; k++) begin
            set_coefs(k);
            push_reading(1'b0, 8'h80, 8'h00, 8'h55);
            push_reading(1'b1, 8'hff, 8'h00, 8'hff);
            push_reading(1'b1, 8'h00, 8'hff, 8'h00);
            drain();
        end

        // random phases with varied idling and settings
        for (phase = 0; phase < 20; phase++) begin
            case (phase % 5)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                3: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            set_coefs(($urandom_range(9) < 7) ? 0 : $urandom_range(3));
            write_reg(REG_OSS, 64'($urandom_range(3)));
            for (int n = 0; n < 100; n++) begin
                logic c;
                c = ($urandom_range(2) == 0) ? 1'b0 : 1'b1;
                if ($urandom_range(9) < 7 && mdl_ac_s[47:32] == 16'd408)
                    // realistic raw ranges around typical readings
                    push_reading(c, 8'($urandom_range(8'h50, 8'h7f)), 8'($urandom),
                                 8'($urandom));
                else
                    push_reading(c, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        drain();
        if (mismatches == 0 && expected_comps.size() == 0)
            $display("PASS baro_temp_pressure_compensate");
        else
            $display("FAIL baro_temp_pressure_compensate");
        $finish;
    end

endmodule

/* baro_temp_pressure_compensate.f */
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_ctrl.sv
hw/rtl/btpc_div.sv
hw/rtl/btpc_dp.sv
hw/rtl/baro_temp_pressure_compensate.sv
test/baro_temp_pressure_compensate_tb.sv
